// ===== design/rcm_pkg.sv =====
package rcm_pkg;

  localparam int unsigned CAPACITY = 9;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CHAN = COLOR_W / CHAN_W;
  localparam int unsigned IN_IDX_W = 4;
  localparam int unsigned CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
  localparam int unsigned ACT_W    = 2;

  localparam logic [CHAN_W-1:0] TOL_RESET = 8'd2;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Shift-insert command toward the entry store
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   upto;
    logic [COLOR_W-1:0] front;
  } rcm_shift_t;

endpackage

// ===== design/rcm_match.sv =====
module rcm_match
  import rcm_pkg::*;
(
  input  logic [COLOR_W-1:0] stored_i,
  input  logic [COLOR_W-1:0] probe_i,
  input  logic [CHAN_W-1:0]  tol_i,
  output logic               match_o
);

  // Per-channel absolute difference against the tolerance
  always_comb begin
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] d;
    match_o = 1'b1;
    for (int c = 0; c < NUM_CHAN; c++) begin
      a = stored_i[c*CHAN_W +: CHAN_W];
      b = probe_i[c*CHAN_W +: CHAN_W];
      d = (a > b) ? (a - b) : (b - a);
      if (d > tol_i) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

// ===== design/rcm_store.sv =====
module rcm_store
  import rcm_pkg::*;
(
  input  logic               clk_i,
  input  rcm_shift_t         shift_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  output logic [COLOR_W-1:0] rd_data_o
);

  logic [COLOR_W-1:0] store_q [CAPACITY];

  // Entries 1..upto take their lower neighbor, front lands at entry 0
  always_ff @(posedge clk_i) begin
    if (shift_i.en) begin
      store_q[0] <= shift_i.front;
      for (int i = 1; i < CAPACITY; i++) begin
        if (IDX_W'(i) <= shift_i.upto) begin
          store_q[i] <= store_q[i-1];
        end
      end
    end
  end

  assign rd_data_o = store_q[rd_idx_i];

endmodule

// ===== design/recent_color_mru_list.sv =====
// Most-recently-used list of RGB colors with tolerant matching.
// Input channel s_axis_*: one item carries an action in tuser (add, read, clear)
// and a color plus an entry index in tdata. Output channel m_axis_*: one result
// item per input item, in order. Config channel cfg_*: writes the per-channel
// match tolerance; it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. Timing: an add scans
// the stored entries one per cycle through a single shared three-channel
// compare unit up to the first match, then shifts the list in the commit state
// and moves to the finish state; a read, a clear or an unused action goes
// straight to the finish state. The input is ready again the cycle after the
// result loads from the finish state. The scan loop over the compare unit sets
// the item rate; the input is not ready while an item is in work.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile and waits in its final step until the
// register frees up.
// Reset: the list is empty (count 0), the tolerance is 2, both channels idle.
// Stored colors have no reset; only entries below the count are ever used.
module recent_color_mru_list
  import rcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CHAN_W-1:0]    cfg_data_i,       // match_tolerance
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,     // color_in[23:0], entry_index[27:24]
  input  logic [ACT_W-1:0]     s_axis_tuser,     // action[1:0]
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata      // hit[0], hit_position[4:1],
                                                 // entry_count[8:5], read_ok[9],
                                                 // color_out[33:10]
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CHAN_W-1:0]   tol_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ACT_W-1:0]    act_q, act_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic                hit_q, hit_d;
  logic                rd_ok_q, rd_ok_d;

  logic                out_valid_q, out_valid_d;
  logic [39:0]         out_data_q, out_data_d;

  logic [COLOR_W-1:0]  rd_data;
  logic                match;
  rcm_shift_t          shift_cmd;

  logic                in_fire;
  logic                out_load;
  logic                scan_last;
  logic [IN_IDX_W-1:0] in_idx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[COLOR_W +: IN_IDX_W];
  assign out_load      = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign scan_last     = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);

  rcm_store u_store (
    .clk_i     (clk_i),
    .shift_i   (shift_cmd),
    .rd_idx_i  (ptr_q),
    .rd_data_o (rd_data)
  );

  rcm_match u_match (
    .stored_i (rd_data),
    .probe_i  (color_q),
    .tol_i    (tol_q),
    .match_o  (match)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    act_d     = act_q;
    color_d   = color_q;
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    rd_ok_d   = rd_ok_q;
    shift_cmd = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d   = s_axis_tuser;
          color_d = s_axis_tdata[COLOR_W-1:0];
          hit_d   = 1'b0;
          rd_ok_d = 1'b0;
          ptr_d   = '0;
          unique case (s_axis_tuser)
            ACT_ADD: begin
              // empty list goes straight to insert
              state_d = (count_q == '0) ? ST_COMMIT : ST_SCAN;
            end
            ACT_READ: begin
              ptr_d   = IDX_W'(in_idx);
              rd_ok_d = (CMP_W'(in_idx) < CMP_W'(count_q));
              state_d = ST_FINISH;
            end
            ACT_CLEAR: begin
              count_d = '0;
              state_d = ST_FINISH;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = ST_COMMIT;
        end else if (scan_last) begin
          state_d = ST_COMMIT;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        shift_cmd.en = 1'b1;
        if (hit_q) begin
          // move the matching entry to the front
          shift_cmd.upto  = ptr_q;
          shift_cmd.front = rd_data;
        end else begin
          // insert new color, drop the oldest when full
          shift_cmd.upto  = IDX_W'(CAPACITY - 1);
          shift_cmd.front = color_q;
          if (count_q < CNT_W'(CAPACITY)) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result item assembly
  always_comb begin
    out_data_d        = out_data_q;
    out_valid_d       = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d        = 1'b1;
      out_data_d         = '0;
      out_data_d[0]      = hit_q;
      out_data_d[4:1]    = hit_q ? 4'(ptr_q) : 4'd0;
      out_data_d[8:5]    = 4'(count_q);
      out_data_d[9]      = rd_ok_q;
      out_data_d[33:10]  = rd_ok_q ? rd_data : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      tol_q       <= TOL_RESET;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      act_q       <= ACT_ADD;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      rd_ok_q     <= rd_ok_d;
      act_q       <= act_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    color_q    <= color_d;
    ptr_q      <= ptr_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> count_q != '0 && act_q == ACT_ADD)
    else $error("scan on empty list or non-add item");

  a_read_excl_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[9] |-> !out_data_q[0])
    else $error("result flags both read and hit");

  a_no_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[9] |-> out_data_q[33:10] == '0)
    else $error("color out nonzero without a read");

endmodule

// ===== dv/mru_list_monitor.sv =====
// Watches the config, input and result channels of the recent-color list.
// Keeps its own copy of the list, predicts one result per accepted item and
// compares every accepted result with the oldest prediction.
module mru_list_monitor
  import rcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CHAN_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [31:0]          s_axis_tdata_i,   // color_in[23:0], entry_index[27:24]
  input  logic [ACT_W-1:0]     s_axis_tuser_i,   // action[1:0]
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [39:0]          m_axis_tdata_i,   // hit[0], hit_position[4:1],
                                                 // entry_count[8:5], read_ok[9],
                                                 // color_out[33:10]
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic               hit;
    logic [3:0]         hit_position;
    logic [3:0]         entry_count;
    logic               read_ok;
    logic [COLOR_W-1:0] color_out;
  } mru_result_t;

  logic [COLOR_W-1:0] mru_colors [CAPACITY];
  int unsigned        mru_count;
  logic [CHAN_W-1:0]  tolerance;
  mru_result_t        expected_results [$];
  mru_result_t        want;
  mru_result_t        got;
  int                 result_num;

  function automatic bit colors_close(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    logic [CHAN_W-1:0] x;
    logic [CHAN_W-1:0] y;
    logic [CHAN_W-1:0] d;
    for (int c = 0; c < NUM_CHAN; c++) begin
      x = a[c*CHAN_W +: CHAN_W];
      y = b[c*CHAN_W +: CHAN_W];
      d = (x > y) ? x - y : y - x;
      if (d > tolerance) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one item to the list copy and return the result it produces.
  function automatic mru_result_t apply_item(logic [ACT_W-1:0] act,
                                             logic [COLOR_W-1:0] color,
                                             logic [3:0] idx);
    mru_result_t        r;
    bit                 found;
    int                 pos;
    logic [COLOR_W-1:0] moved;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    case (act)
      ACT_ADD: begin
        // first match from the front wins
        for (int i = 0; i < int'(mru_count); i++) begin
          if (!found && colors_close(mru_colors[i], color)) begin
            found = 1'b1;
            pos   = i;
          end
        end
        if (found) begin
          moved = mru_colors[pos];
          for (int i = pos; i > 0; i--) mru_colors[i] = mru_colors[i-1];
          mru_colors[0]  = moved;
          r.hit          = 1'b1;
          r.hit_position = pos[3:0];
        end else begin
          if (mru_count < CAPACITY) mru_count++;
          for (int i = int'(mru_count) - 1; i > 0; i--) mru_colors[i] = mru_colors[i-1];
          mru_colors[0] = color;
        end
      end
      ACT_READ: begin
        if (idx < mru_count) begin
          r.read_ok   = 1'b1;
          r.color_out = mru_colors[idx];
        end
      end
      ACT_CLEAR: mru_count = 0;
      default: ;
    endcase
    r.entry_count = mru_count[3:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) mru_colors[i] = '0;
      mru_count    = 0;
      tolerance    = TOL_RESET;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      result_num   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tolerance = cfg_data_i;

      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results.push_back(apply_item(s_axis_tuser_i, s_axis_tdata_i[23:0],
                                              s_axis_tdata_i[27:24]));

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.hit          = m_axis_tdata_i[0];
        got.hit_position = m_axis_tdata_i[4:1];
        got.entry_count  = m_axis_tdata_i[8:5];
        got.read_ok      = m_axis_tdata_i[9];
        got.color_out    = m_axis_tdata_i[33:10];
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result %0d arrived with nothing expected:", result_num,
                     " hit=%0d pos=%0d count=%0d read_ok=%0d color=%06h",
                     got.hit, got.hit_position, got.entry_count,
                     got.read_ok, got.color_out);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.hit_position !== want.hit_position ||
              got.entry_count !== want.entry_count || got.read_ok !== want.read_ok ||
              got.color_out !== want.color_out) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result %0d mismatch:", result_num,
                       " expected hit=%0d pos=%0d count=%0d read_ok=%0d color=%06h,",
                       want.hit, want.hit_position, want.entry_count,
                       want.read_ok, want.color_out,
                       " got hit=%0d pos=%0d count=%0d read_ok=%0d color=%06h",
                       got.hit, got.hit_position,
                       got.entry_count, got.read_ok, got.color_out);
          end
        end
        result_num++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the recent-color list. Items are checked by
// mru_list_monitor; this module drives the three channels and watches for hangs.
module testbench
  import rcm_pkg::*;
();

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int POOL_SIZE = 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CHAN_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;    // color_in[23:0], entry_index[27:24]
  logic [ACT_W-1:0]     s_axis_tuser;    // action[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;    // hit[0], hit_position[4:1], entry_count[8:5],
                                         // read_ok[9], color_out[33:10]
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;

  // Recently added colors, used to aim new adds near stored entries
  logic [COLOR_W-1:0]   color_pool [POOL_SIZE];
  int                   pool_fill;
  int                   pool_next;
  int                   send_calm;
  logic [CHAN_W-1:0]    phase_tol [6];

  recent_color_mru_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mru_list_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang detector: count cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each item, calm stretches with no stall,
  // and two long hold-offs that back the block up into its input.
  initial begin : result_side
    int stall;
    int calm;
    int taken;
    m_axis_tready <= 1'b0;
    calm  = 0;
    taken = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == 100 || taken == 350) begin
        stall = HOLD_OFF_CYCLES;
      end else if (calm != 0) begin
        calm--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        calm  = $urandom_range(5, 20);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  // Offer one item after a random gap; return at the edge that accepts it.
  // Callers either send again or lower tvalid in the same step.
  task automatic send_item(logic [ACT_W-1:0] act, logic [COLOR_W-1:0] color,
                           logic [3:0] idx);
    int gap;
    if (send_calm != 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      send_calm = $urandom_range(5, 20);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, idx, color};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold until every predicted result has come back, then realign to the edge.
  task automatic drain_results();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [CHAN_W-1:0] tol);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Nudge each channel of a pooled color by up to tolerance + 1 steps (at most 8)
  // either side, so below a tolerance of 8 adds land just inside and outside a match.
  function automatic logic [COLOR_W-1:0] near_color(logic [COLOR_W-1:0] base,
                                                    logic [CHAN_W-1:0] tol);
    logic [COLOR_W-1:0] c;
    int span;
    int v;
    span = (tol < 8) ? int'(tol) + 1 : 8;
    c = base;
    for (int k = 0; k < NUM_CHAN; k++) begin
      v = int'(base[k*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 2*span)) - span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      c[k*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
    end
    return c;
  endfunction

  // Mostly adds and reads; clears are rare so the list fills and overflows.
  task automatic send_random_item(logic [CHAN_W-1:0] tol);
    int pick;
    logic [COLOR_W-1:0] color;
    logic [3:0] idx;
    pick  = $urandom_range(0, 99);
    color = COLOR_W'($urandom());
    idx   = 4'($urandom_range(0, 15));
    if (pick < 3) begin
      send_item(ACT_CLEAR, color, idx);
    end else if (pick < 6) begin
      send_item(ACT_UNUSED, color, idx);
    end else if (pick < 36) begin
      if ($urandom_range(0, 9) < 7) idx = 4'($urandom_range(0, CAPACITY - 1));
      send_item(ACT_READ, color, idx);
    end else begin
      if (pool_fill != 0 && $urandom_range(0, 1) == 1)
        color = near_color(color_pool[$urandom_range(0, pool_fill - 1)], tol);
      else if ($urandom_range(0, 15) == 0)
        color = $urandom_range(0, 1) ? {COLOR_W{1'b1}} : '0;
      color_pool[pool_next] = color;
      pool_next = (pool_next + 1) % POOL_SIZE;
      if (pool_fill < POOL_SIZE) pool_fill++;
      send_item(ACT_ADD, color, idx);
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_ADD;
    pool_fill     = 0;
    pool_next     = 0;
    send_calm     = 0;
    phase_tol[0]  = TOL_RESET;
    phase_tol[1]  = 8'd0;
    phase_tol[2]  = 8'd255;
    phase_tol[3]  = 8'd1;
    phase_tol[4]  = 8'($urandom_range(3, 40));
    phase_tol[5]  = 8'd254;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset tolerance of two steps.
    send_item(ACT_READ, 24'h000000, 4'd0);      // read on an empty list
    send_item(ACT_UNUSED, 24'hFFFFFF, 4'd15);   // unused action code
    send_item(ACT_CLEAR, 24'h000000, 4'd0);     // clear an empty list
    send_item(ACT_ADD, 24'h000000, 4'd0);
    send_item(ACT_ADD, 24'hFFFFFF, 4'd15);      // index field ignored on add
    send_item(ACT_ADD, 24'h010101, 4'd0);       // match one step off, position 1
    send_item(ACT_ADD, 24'h030000, 4'd0);       // three steps off: no match
    send_item(ACT_ADD, 24'h020000, 4'd0);       // match at the front
    send_item(ACT_ADD, 24'hFDFFFF, 4'd0);       // exactly at tolerance, position 2
    for (int k = 1; k <= 7; k++)
      send_item(ACT_ADD, COLOR_W'(24'h242424 * k), 4'd0); // overfill: oldest entry drops
    send_item(ACT_READ, 24'h000000, 4'd0);
    send_item(ACT_READ, 24'hFFFFFF, 4'd8);      // last valid position
    send_item(ACT_READ, 24'h000000, 4'd9);      // past the count
    send_item(ACT_READ, 24'h000000, 4'd15);
    send_item(ACT_ADD, 24'h040101, 4'd0);       // match on the last entry
    send_item(ACT_UNUSED, 24'h000000, 4'd3);    // unused code on a full list
    send_item(ACT_CLEAR, 24'hFFFFFF, 4'd15);
    send_item(ACT_READ, 24'h000000, 4'd0);      // read right after a clear
    s_axis_tvalid <= 1'b0;

    // Random phases, each at its own tolerance.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_tolerance(phase_tol[p]);
      for (int n = 0; n < 90; n++) send_random_item(phase_tol[p]);
      s_axis_tvalid <= 1'b0;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
